// File: sv/arphv_pkg.sv
`timescale 1ns / 1ps

package arphv_pkg;

   // Packet geometry
   localparam int CNT_W       = 11;
   localparam int CNT_MAX     = 2047;
   localparam int HDR_LEN     = 8;
   localparam int MAC_LEN     = 6;
   localparam int IP_LEN      = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [15:0] ETH_HW     = 16'h0001;
   localparam logic [15:0] IPV4_PROTO = 16'h0800;
   localparam logic [7:0]  ETH_HLN    = 8'd6;
   localparam logic [7:0]  IPV4_PLN   = 8'd4;

   // Fixed header offsets
   localparam logic [2:0] OFS_HW_HI    = 3'd0;
   localparam logic [2:0] OFS_HW_LO    = 3'd1;
   localparam logic [2:0] OFS_PROTO_HI = 3'd2;
   localparam logic [2:0] OFS_PROTO_LO = 3'd3;
   localparam logic [2:0] OFS_HLN      = 3'd4;
   localparam logic [2:0] OFS_PLN      = 3'd5;
   localparam logic [2:0] OFS_OP_HI    = 3'd6;
   localparam logic [2:0] OFS_OP_LO    = 3'd7;

   // Opcodes
   localparam logic [15:0] OP_REQUEST   = 16'd1;
   localparam logic [15:0] OP_REPLY     = 16'd2;
   localparam logic [15:0] OP_RREQUEST  = 16'd3;
   localparam logic [15:0] OP_RREPLY    = 16'd4;
   localparam logic [15:0] OP_INREQUEST = 16'd8;
   localparam logic [15:0] OP_INREPLY   = 16'd9;

   typedef enum logic [3:0] {
      VERDICT_REQUEST       = 4'd0,
      VERDICT_REPLY         = 4'd1,
      VERDICT_TRUNCATED     = 4'd2,
      VERDICT_UNKNOWN_HW    = 4'd3,
      VERDICT_BAD_HW_LEN    = 4'd4,
      VERDICT_UNKNOWN_PROTO = 4'd5,
      VERDICT_BAD_PROTO_LEN = 4'd6,
      VERDICT_SENDER_MISM   = 4'd7,
      VERDICT_UNIMPL_OP     = 4'd8,
      VERDICT_INVALID_OP    = 4'd9
   } verdict_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [47:0] frame_src_mac;
      logic [47:0] frame_dst_mac;
   } req_type;

   typedef struct packed {
      logic [3:0]  verdict;
      logic [47:0] src_mac_out;
      logic [47:0] dst_mac_out;
      logic [47:0] sender_mac;
      logic [31:0] sender_ip;
      logic [47:0] target_mac;
      logic [31:0] target_ip;
   } rsp_type;

   // Classified beat handed from front to back
   typedef struct packed {
      logic [7:0]  data;
      logic        first;
      logic        last;
      logic        hdr_hit;
      logic [2:0]  hdr_idx;
      logic        smac_hit;
      logic [2:0]  smac_lane;
      logic        sip_hit;
      logic [1:0]  sip_lane;
      logic        tmac_hit;
      logic [2:0]  tmac_lane;
      logic        tip_hit;
      logic [1:0]  tip_lane;
      logic        trunc;
      logic        hln_ok;
      logic        pln_ok;
      logic [47:0] src_mac;
      logic [47:0] dst_mac;
   } cmd_type;

endpackage

// File: sv/arphv_front.sv
`timescale 1ns / 1ps

module arphv_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  arphv_pkg::req_type  req_data,
   input  logic                q_full,
   output logic                req_stall,
   output logic                q_push,
   output arphv_pkg::cmd_type  q_cmd
);

   logic [arphv_pkg::CNT_W-1:0] p_ff, p_in;
   logic [7:0]  hln_ff, hln_in, pln_ff, pln_in;
   logic [7:0]  hln_cur, pln_cur;
   logic        first;
   logic [11:0] p12, need;
   logic [11:0] smac_diff, sip_base, sip_diff, tmac_base, tmac_diff, tip_base, tip_diff;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign first     = (p_ff == '0);
   assign p12       = {1'b0, p_ff};

   always_comb begin
      hln_cur = hln_ff;
      pln_cur = pln_ff;
      if (first) begin
         hln_cur = '0;
         pln_cur = '0;
      end else if (p_ff == arphv_pkg::CNT_W'(arphv_pkg::OFS_HLN)) begin
         hln_cur = req_data.data_byte;
      end else if (p_ff == arphv_pkg::CNT_W'(arphv_pkg::OFS_PLN)) begin
         pln_cur = req_data.data_byte;
      end
   end

   // Address windows; bases sit at or past the fixed header, so lengths are final here
   assign sip_base  = 12'(arphv_pkg::HDR_LEN) + {4'b0, hln_ff};
   assign tmac_base = sip_base + {4'b0, pln_ff};
   assign tip_base  = tmac_base + {4'b0, hln_ff};
   assign smac_diff = p12 - 12'(arphv_pkg::HDR_LEN);
   assign sip_diff  = p12 - sip_base;
   assign tmac_diff = p12 - tmac_base;
   assign tip_diff  = p12 - tip_base;
   assign need      = 12'(arphv_pkg::HDR_LEN) + {3'b0, hln_cur, 1'b0} + {3'b0, pln_cur, 1'b0};

   always_comb begin
      q_cmd           = '0;
      q_cmd.data      = req_data.data_byte;
      q_cmd.first     = first;
      q_cmd.last      = req_data.last_byte;
      q_cmd.hdr_hit   = (p12 < 12'(arphv_pkg::HDR_LEN));
      q_cmd.hdr_idx   = p_ff[2:0];
      q_cmd.smac_hit  = (p12 >= 12'(arphv_pkg::HDR_LEN))
                        && (smac_diff < 12'(arphv_pkg::MAC_LEN));
      q_cmd.smac_lane = 3'(arphv_pkg::MAC_LEN - 1) - smac_diff[2:0];
      q_cmd.sip_hit   = (p12 >= sip_base) && (sip_diff < 12'(arphv_pkg::IP_LEN));
      q_cmd.sip_lane  = 2'(arphv_pkg::IP_LEN - 1) - sip_diff[1:0];
      q_cmd.tmac_hit  = (p12 >= tmac_base) && (tmac_diff < 12'(arphv_pkg::MAC_LEN));
      q_cmd.tmac_lane = 3'(arphv_pkg::MAC_LEN - 1) - tmac_diff[2:0];
      q_cmd.tip_hit   = (p12 >= tip_base) && (tip_diff < 12'(arphv_pkg::IP_LEN));
      q_cmd.tip_lane  = 2'(arphv_pkg::IP_LEN - 1) - tip_diff[1:0];
      q_cmd.trunc     = ((p12 + 12'd1) < need);
      q_cmd.hln_ok    = (hln_cur == arphv_pkg::ETH_HLN);
      q_cmd.pln_ok    = (pln_cur == arphv_pkg::IPV4_PLN);
      q_cmd.src_mac   = req_data.frame_src_mac;
      q_cmd.dst_mac   = req_data.frame_dst_mac;
   end

   always_comb begin
      p_in   = p_ff;
      hln_in = hln_ff;
      pln_in = pln_ff;
      if (q_push) begin
         hln_in = hln_cur;
         pln_in = pln_cur;
         if (req_data.last_byte) begin
            p_in = '0;
         end else if (p_ff != arphv_pkg::CNT_W'(arphv_pkg::CNT_MAX)) begin
            p_in = p_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff   <= '0;
         hln_ff <= '0;
         pln_ff <= '0;
      end else begin
         p_ff   <= p_in;
         hln_ff <= hln_in;
         pln_ff <= pln_in;
      end
   end

endmodule

// File: sv/arphv_queue.sv
`timescale 1ns / 1ps

module arphv_queue #(
   parameter int DEPTH = arphv_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  arphv_pkg::cmd_type  push_cmd,
   output logic                full,
   input  logic                pop,
   output logic                pop_valid,
   output arphv_pkg::cmd_type  pop_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   arphv_pkg::cmd_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: sv/arphv_back.sv
`timescale 1ns / 1ps

module arphv_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  arphv_pkg::cmd_type  q_cmd,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output arphv_pkg::rsp_type  rsp_data
);

   logic [15:0] hw_type_ff, hw_type_in, proto_type_ff, proto_type_in, op_code_ff, op_code_in;
   logic [47:0] sender_mac_ff, sender_mac_in, target_mac_ff, target_mac_in;
   logic [31:0] sender_ip_ff, sender_ip_in, target_ip_ff, target_ip_in;
   logic [47:0] src_mac_ff, src_mac_in, dst_mac_ff, dst_mac_in;
   logic        rsp_valid_ff, rsp_valid_in;
   arphv_pkg::rsp_type     rsp_ff, rsp_in;
   arphv_pkg::verdict_type verdict;

   // Non-final beats never wait on the result side
   assign q_pop     = q_valid && (!q_cmd.last || !rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      hw_type_in    = q_cmd.first ? '0 : hw_type_ff;
      proto_type_in = q_cmd.first ? '0 : proto_type_ff;
      op_code_in    = q_cmd.first ? '0 : op_code_ff;
      sender_mac_in = q_cmd.first ? '0 : sender_mac_ff;
      sender_ip_in  = q_cmd.first ? '0 : sender_ip_ff;
      target_mac_in = q_cmd.first ? '0 : target_mac_ff;
      target_ip_in  = q_cmd.first ? '0 : target_ip_ff;
      src_mac_in    = q_cmd.first ? q_cmd.src_mac : src_mac_ff;
      dst_mac_in    = q_cmd.first ? q_cmd.dst_mac : dst_mac_ff;

      if (q_cmd.hdr_hit) begin
         unique case (q_cmd.hdr_idx)
            arphv_pkg::OFS_HW_HI:    hw_type_in[15:8]    = q_cmd.data;
            arphv_pkg::OFS_HW_LO:    hw_type_in[7:0]     = q_cmd.data;
            arphv_pkg::OFS_PROTO_HI: proto_type_in[15:8] = q_cmd.data;
            arphv_pkg::OFS_PROTO_LO: proto_type_in[7:0]  = q_cmd.data;
            arphv_pkg::OFS_OP_HI:    op_code_in[15:8]    = q_cmd.data;
            arphv_pkg::OFS_OP_LO:    op_code_in[7:0]     = q_cmd.data;
            default: ;
         endcase
      end

      // Overlapping windows each take the byte
      for (int i = 0; i < arphv_pkg::MAC_LEN; i++) begin
         if (q_cmd.smac_hit && q_cmd.smac_lane == 3'(i)) sender_mac_in[8*i +: 8] = q_cmd.data;
         if (q_cmd.tmac_hit && q_cmd.tmac_lane == 3'(i)) target_mac_in[8*i +: 8] = q_cmd.data;
      end
      for (int i = 0; i < arphv_pkg::IP_LEN; i++) begin
         if (q_cmd.sip_hit && q_cmd.sip_lane == 2'(i)) sender_ip_in[8*i +: 8] = q_cmd.data;
         if (q_cmd.tip_hit && q_cmd.tip_lane == 2'(i)) target_ip_in[8*i +: 8] = q_cmd.data;
      end
   end

   always_comb begin
      if (q_cmd.trunc) begin
         verdict = arphv_pkg::VERDICT_TRUNCATED;
      end else if (hw_type_in != arphv_pkg::ETH_HW) begin
         verdict = arphv_pkg::VERDICT_UNKNOWN_HW;
      end else if (!q_cmd.hln_ok) begin
         verdict = arphv_pkg::VERDICT_BAD_HW_LEN;
      end else if (proto_type_in != arphv_pkg::IPV4_PROTO) begin
         verdict = arphv_pkg::VERDICT_UNKNOWN_PROTO;
      end else if (!q_cmd.pln_ok) begin
         verdict = arphv_pkg::VERDICT_BAD_PROTO_LEN;
      end else if (sender_mac_in != src_mac_in) begin
         verdict = arphv_pkg::VERDICT_SENDER_MISM;
      end else begin
         case (op_code_in) inside
            arphv_pkg::OP_REQUEST: verdict = arphv_pkg::VERDICT_REQUEST;
            arphv_pkg::OP_REPLY:   verdict = arphv_pkg::VERDICT_REPLY;
            arphv_pkg::OP_RREQUEST, arphv_pkg::OP_RREPLY,
            arphv_pkg::OP_INREQUEST, arphv_pkg::OP_INREPLY:
                                   verdict = arphv_pkg::VERDICT_UNIMPL_OP;
            default:               verdict = arphv_pkg::VERDICT_INVALID_OP;
         endcase
      end
   end

   always_comb begin
      rsp_in             = rsp_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      if (q_pop && q_cmd.last) begin
         rsp_valid_in       = 1'b1;
         rsp_in.verdict     = verdict;
         rsp_in.src_mac_out = src_mac_in;
         rsp_in.dst_mac_out = dst_mac_in;
         rsp_in.sender_mac  = sender_mac_in;
         rsp_in.sender_ip   = sender_ip_in;
         rsp_in.target_mac  = target_mac_in;
         rsp_in.target_ip   = target_ip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         hw_type_ff    <= hw_type_in;
         proto_type_ff <= proto_type_in;
         op_code_ff    <= op_code_in;
         sender_mac_ff <= sender_mac_in;
         sender_ip_ff  <= sender_ip_in;
         target_mac_ff <= target_mac_in;
         target_ip_ff  <= target_ip_in;
         src_mac_ff    <= src_mac_in;
         dst_mac_ff    <= dst_mac_in;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: sv/arp_header_validator.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake             Payload
// req      in   req_valid/req_stall   arphv_pkg::req_type, one packet byte per beat
// rsp      out  rsp_valid/rsp_stall   arphv_pkg::rsp_type, one verdict per packet
//
// Takes one byte per cycle when not stalled; the front counts and classifies each byte
// combinationally. The back pops the last beat from the queue and registers the verdict.
// Reset clears the byte counter, lengths, queue and result valid; payload is not reset.
// req_stall rises only when the front-to-back queue is full, which happens when the
// result register is held by rsp_stall and a further last beat is waiting.

module arp_header_validator #(
   parameter int QUEUE_DEPTH = arphv_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  arphv_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output arphv_pkg::rsp_type  rsp_data
);

   logic               q_push, q_full, q_pop, q_valid;
   arphv_pkg::cmd_type push_cmd, pop_cmd;

   // Front: count bytes, track lengths, map each byte to its field and lane
   arphv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .q_full    (q_full),
      .req_stall (req_stall),
      .q_push    (q_push),
      .q_cmd     (push_cmd)
   );

   // Short queue: lets the front keep taking beats while the result is held
   arphv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_cmd   (pop_cmd)
   );

   // Back: capture fields, decide the verdict, hold the result
   arphv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (pop_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Never push into a full queue
   assert property (@(posedge clock) disable iff (reset) q_full |-> !q_push)
      else $error("push into full queue");

   // A held result is never overwritten by a new verdict
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !(q_pop && pop_cmd.last))
      else $error("held result overwritten");

   // A taken result with nothing new behind it drops valid
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !(q_pop && pop_cmd.last)) |=> !rsp_valid)
      else $error("result repeated");

   // Pops only come from a non-empty queue
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("pop from empty queue");

endmodule
